### src/rthsv_pkg.sv
// Package for the RGB to HSV converter: field widths, scaling constants,
// the hue sector code and the record that travels down the divider stages.
// No dependencies.
package rthsv_pkg;

   // Channel width actually used from each 16-bit input field (8 to 16).
   localparam int CHAN_BITS      = 16;
   localparam int FIELD_BITS     = 16;
   localparam int IN_TDATA_BITS  = 3 * FIELD_BITS;

   localparam int HUE_BITS       = 15;
   localparam int SAT_BITS       = 13;
   localparam int VAL_BITS       = 21;
   localparam int OUT_FIELD_BITS = HUE_BITS + SAT_BITS + VAL_BITS;
   localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
   localparam int OUT_PAD_BITS   = OUT_TDATA_BITS - OUT_FIELD_BITS;

   // Both quotients are below 2^13 (hue offset at most 3840, saturation at most 6400).
   localparam int QUOT_BITS      = 13;
   localparam int NUM_BITS       = CHAN_BITS + QUOT_BITS;
   localparam int VAL_Y_BITS     = CHAN_BITS + 5;

   // Input register, min/max stage, operand stage, one stage per quotient bit, output.
   localparam int DIV_FIRST      = 3;
   localparam int STAGE_COUNT    = DIV_FIRST + QUOT_BITS + 1;

   localparam int HUE_FULL_Q6    = 23040;   // 360 degrees
   localparam int HUE_STEP_Q6    = 3840;    // 60 degrees
   localparam int HUE_BASE_RED   = 23040;   // 360 degrees
   localparam int HUE_BASE_GREEN = 7680;    // 120 degrees
   localparam int HUE_BASE_BLUE  = 15360;   // 240 degrees
   localparam int SAT_SCALE      = 6400;    // 100 percent
   localparam int VAL_MUL        = 25;      // 6400 = 25 * 255 + 25
   localparam int VAL_DIV        = 255;
   localparam int RECIP_SHIFT    = 8;       // 255 = 2^8 - 1

   typedef enum logic [2:0] {
      SEC_RED   = 3'b001,
      SEC_GREEN = 3'b010,
      SEC_BLUE  = 3'b100
   } sector_type;

   typedef struct packed {
      logic [NUM_BITS-1:0]   hue_rem;
      logic [CHAN_BITS-1:0]  hue_div;
      logic [QUOT_BITS-1:0]  hue_quot;
      logic                  hue_neg;
      logic [HUE_BITS-1:0]   hue_base;
      logic [NUM_BITS-1:0]   sat_rem;
      logic [CHAN_BITS-1:0]  sat_div;
      logic [QUOT_BITS-1:0]  sat_quot;
      logic                  grey;
      logic                  black;
      logic [VAL_Y_BITS-1:0] val_y;
      logic [VAL_BITS-1:0]   val_q;
      logic                  val_fix;
   } div_type;

endpackage

### src/rgb_to_hsv_converter.sv
// Pipelined RGB to HSV converter with 6 fractional bits on every result.
// Depends on rthsv_pkg for widths, constants, the sector code and div_type.
//
// Usage:
//   req_* carries one sample per transaction: red, green and blue counts.
//   rsp_* returns hue (1/64 degree), saturation (1/64 percent) and
//   value (1/64 units) for each sample, in the order they were accepted.
//   Each accepted sample passes through the input register, the min/max
//   stage, the operand stage, 13 divider stages and the output register.
//   Throughput: one sample per cycle unless the receiver stalls. Hue and
//   saturation are two restoring dividers that resolve one quotient bit per
//   pipeline stage, so every stage holds its own sample.
//   Each stage has its own valid bit and moves forward whenever the stage
//   ahead of it is empty or moving, so bubbles close up when the receiver
//   stalls and req_tready only drops once every stage is full.
//   Reset clears all valid bits; no result is offered until a new sample
//   has passed through.
//   Input bits above the channel width are ignored.
module rgb_to_hsv_converter
   import rthsv_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // Fields from bit 0 up: red_raw[15:0], green_raw[15:0], blue_raw[15:0].
   input  logic [IN_TDATA_BITS-1:0]  req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // Fields from bit 0 up: hue_q6[14:0], sat_q6[12:0], value_q6[20:0], zero pad.
   output logic [OUT_TDATA_BITS-1:0] rsp_tdata
);

   localparam int OUT_STG = STAGE_COUNT - 1;

   // Stage handshake.
   logic [STAGE_COUNT:0]   rdy;
   logic [STAGE_COUNT-1:0] vld_ff, vld_in, vld_src, load;

   // Stage 0: input register.
   logic [CHAN_BITS-1:0] red_ff, green_ff, blue_ff;
   logic [CHAN_BITS-1:0] red_in, green_in, blue_in;

   // Stage 1: extremes, sector and signed channel difference.
   logic [CHAN_BITS-1:0] cmax_ff, cmin_ff, cmax_in, cmin_in;
   sector_type           sector_ff, sector_in;
   logic [CHAN_BITS:0]   dlt_ff, dlt_in;

   // Stage 2 and the divider stages.
   div_type div_ff [QUOT_BITS+1];
   div_type div_in [QUOT_BITS+1];
   logic [CHAN_BITS-1:0] diff;
   logic [CHAN_BITS:0]   dlt_abs;

   // Output stage.
   logic [HUE_BITS-1:0] hue_ff, hue_in;
   logic [SAT_BITS-1:0] sat_ff, sat_in;
   logic [VAL_BITS-1:0] val_ff, val_in;
   logic [HUE_BITS:0]   hue_raw;

   assign rdy[STAGE_COUNT] = rsp_tready;

   genvar s;
   generate
      for (s = 0; s < STAGE_COUNT; s++) begin : g_hs
         assign rdy[s] = !vld_ff[s] || rdy[s+1];
      end
   endgenerate

   assign vld_src = {vld_ff[STAGE_COUNT-2:0], req_tvalid};
   assign load    = rdy[STAGE_COUNT-1:0] & vld_src;
   assign vld_in  = (rdy[STAGE_COUNT-1:0] & vld_src) | (~rdy[STAGE_COUNT-1:0] & vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_tready = rdy[0];
   assign rsp_tvalid = vld_ff[OUT_STG];

   // ---------------- Stage 0 ----------------
   assign red_in   = req_tdata[0 +: CHAN_BITS];
   assign green_in = req_tdata[FIELD_BITS +: CHAN_BITS];
   assign blue_in  = req_tdata[2*FIELD_BITS +: CHAN_BITS];

   always_ff @(posedge clock) begin
      if (load[0]) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   // ---------------- Stage 1 ----------------
   always_comb begin
      cmax_in = red_ff;
      if (green_ff > cmax_in) cmax_in = green_ff;
      if (blue_ff > cmax_in) cmax_in = blue_ff;
      cmin_in = red_ff;
      if (green_ff < cmin_in) cmin_in = green_ff;
      if (blue_ff < cmin_in) cmin_in = blue_ff;

      // Ties for the maximum go to red, then green.
      if (cmax_in == red_ff) begin
         sector_in = SEC_RED;
      end else if (cmax_in == green_ff) begin
         sector_in = SEC_GREEN;
      end else begin
         sector_in = SEC_BLUE;
      end

      case (sector_in)
         SEC_RED: begin
            dlt_in = {1'b0, green_ff} - {1'b0, blue_ff};
         end
         SEC_GREEN: begin
            dlt_in = {1'b0, blue_ff} - {1'b0, red_ff};
         end
         default: begin
            dlt_in = {1'b0, red_ff} - {1'b0, green_ff};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         cmax_ff   <= cmax_in;
         cmin_ff   <= cmin_in;
         sector_ff <= sector_in;
         dlt_ff    <= dlt_in;
      end
   end

   // ---------------- Stage 2: dividend and divisor set-up ----------------
   // The hue is base + floor(3840 * d / diff), with |d| <= diff, so only the
   // magnitude is divided and the sign is applied at the end.
   always_comb begin
      diff    = cmax_ff - cmin_ff;
      dlt_abs = dlt_ff[CHAN_BITS] ? (~dlt_ff + 1'b1) : dlt_ff;

      div_in[0].hue_rem  = NUM_BITS'(dlt_abs[CHAN_BITS-1:0]) * NUM_BITS'(HUE_STEP_Q6);
      div_in[0].hue_div  = diff;
      div_in[0].hue_quot = '0;
      div_in[0].hue_neg  = dlt_ff[CHAN_BITS];
      case (sector_ff)
         SEC_RED:   div_in[0].hue_base = HUE_BITS'(HUE_BASE_RED);
         SEC_GREEN: div_in[0].hue_base = HUE_BITS'(HUE_BASE_GREEN);
         default:   div_in[0].hue_base = HUE_BITS'(HUE_BASE_BLUE);
      endcase
      div_in[0].sat_rem  = NUM_BITS'(diff) * NUM_BITS'(SAT_SCALE);
      div_in[0].sat_div  = cmax_ff;
      div_in[0].sat_quot = '0;
      div_in[0].grey     = (diff == '0);
      div_in[0].black    = (cmax_ff == '0);
      div_in[0].val_y    = VAL_Y_BITS'(cmax_ff) * VAL_Y_BITS'(VAL_MUL);
      div_in[0].val_q    = '0;
      div_in[0].val_fix  = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (load[2]) begin
         div_ff[0] <= div_in[0];
      end
   end

   // ---------------- Divider stages ----------------
   // Each stage resolves one quotient bit of both divisions, MSB first.
   // The value path rides along: y / 255 is estimated from y / 256 terms in
   // the first stage, checked against the remainder in the second and added
   // to y in the third (cmax * 6400 / 255 = y + y / 255 with y = 25 * cmax).
   genvar k;
   generate
      for (k = 0; k < QUOT_BITS; k++) begin : g_div
         localparam int SHIFT = QUOT_BITS - 1 - k;

         logic [NUM_BITS-1:0]   hue_shf, sat_shf;
         logic [VAL_Y_BITS:0]   val_sum;
         logic [VAL_Y_BITS-1:0] val_rem;

         always_comb begin
            hue_shf = NUM_BITS'(div_ff[k].hue_div) << SHIFT;
            sat_shf = NUM_BITS'(div_ff[k].sat_div) << SHIFT;
            val_sum = {1'b0, div_ff[k].val_y} + (div_ff[k].val_y >> RECIP_SHIFT)
                      + (div_ff[k].val_y >> (2 * RECIP_SHIFT));
            val_rem = div_ff[k].val_y
                      - VAL_Y_BITS'(div_ff[k].val_q) * VAL_Y_BITS'(VAL_DIV);

            div_in[k+1] = div_ff[k];
            if (div_ff[k].hue_rem >= hue_shf) begin
               div_in[k+1].hue_rem         = div_ff[k].hue_rem - hue_shf;
               div_in[k+1].hue_quot[SHIFT] = 1'b1;
            end
            if (div_ff[k].sat_rem >= sat_shf) begin
               div_in[k+1].sat_rem         = div_ff[k].sat_rem - sat_shf;
               div_in[k+1].sat_quot[SHIFT] = 1'b1;
            end

            if (k == 0) begin
               div_in[k+1].val_q = VAL_BITS'(val_sum >> RECIP_SHIFT);
            end else if (k == 1) begin
               div_in[k+1].val_fix = (val_rem >= VAL_Y_BITS'(VAL_DIV));
            end else if (k == 2) begin
               div_in[k+1].val_q = VAL_BITS'(div_ff[k].val_y) + div_ff[k].val_q
                                   + VAL_BITS'(div_ff[k].val_fix);
            end
         end

         always_ff @(posedge clock) begin
            if (load[DIV_FIRST+k]) begin
               div_ff[k+1] <= div_in[k+1];
            end
         end
      end
   endgenerate

   // ---------------- Output stage ----------------
   // A negative offset floors downward, so a nonzero remainder costs one more.
   always_comb begin
      if (div_ff[QUOT_BITS].hue_neg) begin
         hue_raw = {1'b0, div_ff[QUOT_BITS].hue_base}
                   - (HUE_BITS+1)'(div_ff[QUOT_BITS].hue_quot)
                   - (HUE_BITS+1)'(div_ff[QUOT_BITS].hue_rem != '0);
      end else begin
         hue_raw = {1'b0, div_ff[QUOT_BITS].hue_base}
                   + (HUE_BITS+1)'(div_ff[QUOT_BITS].hue_quot);
      end

      if (div_ff[QUOT_BITS].grey) begin
         hue_in = '0;
      end else if (hue_raw >= (HUE_BITS+1)'(HUE_FULL_Q6)) begin
         hue_in = HUE_BITS'(hue_raw - (HUE_BITS+1)'(HUE_FULL_Q6));
      end else begin
         hue_in = HUE_BITS'(hue_raw);
      end

      sat_in = div_ff[QUOT_BITS].black ? '0 : SAT_BITS'(div_ff[QUOT_BITS].sat_quot);
      val_in = div_ff[QUOT_BITS].val_q;
   end

   always_ff @(posedge clock) begin
      if (load[OUT_STG]) begin
         hue_ff <= hue_in;
         sat_ff <= sat_in;
         val_ff <= val_in;
      end
   end

   assign rsp_tdata = {{OUT_PAD_BITS{1'b0}}, val_ff, sat_ff, hue_ff};

   // ---------------- Assertions ----------------
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (hue_ff < HUE_BITS'(HUE_FULL_Q6)) && (sat_ff <= SAT_BITS'(SAT_SCALE)))
      else $error("hue or saturation out of range");

   a_grey_hue: assert property (@(posedge clock) disable iff (reset)
      (load[OUT_STG] && div_ff[QUOT_BITS].grey) |=> (hue_ff == '0))
      else $error("grey sample produced nonzero hue");

   a_full_only: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> ((&vld_ff) && !rsp_tready))
      else $error("input stalled while the pipeline has a free stage");

endmodule
